@@ rtl/core/mne_pkg.sv @@
// mne_pkg: shared widths, codes and byte constants of the MIDI note event encoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mne_pkg;

    // field widths
    localparam int STAMP_WIDTH   = 31;
    localparam int VLQ_MAX_BYTES = 5;
    localparam int PITCH_W       = 7;
    localparam int VEL_W         = 7;
    localparam int BYTE_W        = 8;
    localparam int RATIO_W       = 48;
    localparam int RATIO_FRAC_W  = 32;
    localparam int RATIO_INT_W   = 16;
    localparam int CFG_IDX_W     = 1;

    // shared multiplier and tick arithmetic widths
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ROUND_W = PROD_W + 1;
    localparam int SUM_W   = STAMP_WIDTH + RATIO_INT_W + 1;
    localparam int DELTA_W = (VLQ_MAX_BYTES * 7 >= 32) ? 32 : VLQ_MAX_BYTES * 7;
    localparam int CMP_W   = (SUM_W > DELTA_W) ? SUM_W : DELTA_W;
    localparam logic [DELTA_W-1:0] DELTA_CAP  = '1;
    localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(1) << (RATIO_FRAC_W - 1);

    // byte position inside one event: vlq bytes, status, pitch, velocity
    localparam int POS_W   = $clog2(VLQ_MAX_BYTES + 3);
    localparam int EOT_LEN = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATIO    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_VELOCITY = CFG_IDX_W'(1);

    // register reset values
    localparam logic [RATIO_W-1:0] TICK_RATIO_RESET = RATIO_W'(9349594);
    localparam logic [VEL_W-1:0]   VELOCITY_RESET   = VEL_W'(80);

    // request codes
    localparam logic FUNC_NOTE = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // status and meta bytes
    localparam logic [BYTE_W-1:0] NOTE_ON_STATUS  = 8'h90;
    localparam logic [BYTE_W-1:0] NOTE_OFF_STATUS = 8'h80;
    localparam logic [BYTE_W-1:0] META_STATUS     = 8'hFF;
    localparam logic [BYTE_W-1:0] META_END_TRACK  = 8'h2F;
    localparam logic [BYTE_W-1:0] EOT_DELTA_BYTE  = 8'h02;
    localparam logic [BYTE_W-1:0] EOT_LEN_BYTE    = 8'h00;

    // response of the tick unit
    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] ticks;
    } t_tick_rsp;

    // end-of-track event bytes by position
    function automatic logic [BYTE_W-1:0] eot_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0:    b = EOT_DELTA_BYTE;
            2'd1:    b = META_STATUS;
            2'd2:    b = META_END_TRACK;
            default: b = EOT_LEN_BYTE;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/mne_tick_unit.sv @@
// mne_tick_unit: converts a sample difference to midi ticks with one shared multiplier
// depends on mne_pkg
`timescale 1ns / 1ps

module mne_tick_unit import mne_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [STAMP_WIDTH-1:0] i_diff,
    input  logic [RATIO_W-1:0]     i_ratio,
    output t_tick_rsp              o_rsp
);

    typedef enum logic [1:0] {T_IDLE, T_LO, T_HI, T_SUM} t_state;

    t_state                   r_state, n_state;
    logic [STAMP_WIDTH-1:0]   r_diff;
    logic [PROD_W-1:0]        r_prod;
    logic [SUM_W-1:0]         r_frac;
    t_tick_rsp                r_rsp;

    logic [MUL_W-1:0]   w_mul_a;
    logic [MUL_W-1:0]   w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [ROUND_W-1:0] w_round;
    logic [SUM_W-1:0]   w_sum;
    logic               w_sat;

    // shared multiplier: fraction part of the ratio first, then the integer part
    assign w_mul_a = MUL_W'(r_diff);
    assign w_mul_b = (r_state == T_LO) ? i_ratio[RATIO_FRAC_W-1:0]
                                       : MUL_W'(i_ratio[RATIO_W-1:RATIO_FRAC_W]);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // round half up of the fraction product, then integer sum and saturation
    assign w_round = ROUND_W'(r_prod) + ROUND_HALF;
    assign w_sum   = SUM_W'(r_prod) + r_frac;
    assign w_sat   = CMP_W'(w_sum) > CMP_W'(DELTA_CAP);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE:  if (i_start) n_state = T_LO;
            T_LO:    n_state = T_HI;
            T_HI:    n_state = T_SUM;
            T_SUM:   n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_IDLE && i_start) begin
            r_diff <= i_diff;
        end
        if (r_state == T_LO) begin
            r_prod <= w_prod;
        end
        if (r_state == T_HI) begin
            r_frac <= SUM_W'(w_round[ROUND_W-1:RATIO_FRAC_W]);
            r_prod <= w_prod;
        end
        if (r_state == T_SUM) begin
            r_rsp.ticks <= w_sat ? DELTA_CAP : DELTA_W'(w_sum);
        end
        if (!i_rst_n) begin
            r_state    <= T_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rsp.done <= (r_state == T_SUM);
        end
    end

    assign o_rsp = r_rsp;

endmodule

@@ rtl/core/midi_note_event_encoder_top.sv @@
// midi_note_event_encoder_top: sequencer, stamp state, config registers and byte output
// depends on mne_pkg and mne_tick_unit
`timescale 1ns / 1ps

// A note request (func 0) produces a note-on then a note-off track event, each as a
// big-endian VLQ delta time followed by status, pitch and the configured velocity; an
// end-of-track request (func 1) produces 02 FF 2F 00. Delta times are the stamp minus the
// previous stamp scaled by tick_ratio (Q16.32), rounded half up and saturated; a backward
// stamp gives delta 0 and raises order_error on every byte of that note. Words are taken
// one request at a time: o_in_stall stays high from acceptance until the last byte has
// been loaded into the output register. A note makes two passes through the shared tick
// multiplier, then loads one byte per cycle into the output register while it is free
// (8 to 16 bytes); end of track loads its four bytes the same way. Output bytes
// stall independently through a one-word output register. Configuration is always ready
// and must only be written while no request is in flight.

module midi_note_event_encoder_top import mne_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request words
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_func,
    input  logic [PITCH_W-1:0]     i_pitch,
    input  logic [STAMP_WIDTH-1:0] i_start_stamp,
    input  logic [STAMP_WIDTH-1:0] i_stop_stamp,
    // byte words
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [BYTE_W-1:0]      o_out_byte,
    output logic                   o_last_byte,
    output logic                   o_order_error,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [RATIO_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_ON, S_OFF, S_EMIT} t_state;

    // control registers
    t_state                 r_state, n_state;
    logic [STAMP_WIDTH-1:0] r_prev, n_prev;
    logic [RATIO_W-1:0]     r_ratio, n_ratio;
    logic [VEL_W-1:0]       r_vel, n_vel;
    logic                   r_out_valid, n_out_valid;
    // payload registers
    logic                   r_func, n_func;
    logic [PITCH_W-1:0]     r_pitch, n_pitch;
    logic [STAMP_WIDTH-1:0] r_stop, n_stop;
    logic                   r_err, n_err;
    logic [DELTA_W-1:0]     r_ticks_on, n_ticks_on;
    logic [DELTA_W-1:0]     r_ticks_off, n_ticks_off;
    logic                   r_evt, n_evt;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [BYTE_W-1:0]      r_out_byte, n_out_byte;
    logic                   r_out_last, n_out_last;
    logic                   r_out_err, n_out_err;

    // tick unit link
    logic                   w_tick_start;
    logic [STAMP_WIDTH-1:0] w_tick_diff;
    t_tick_rsp              w_tick_rsp;

    // byte selection
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [DELTA_W-1:0]     w_cur_ticks;
    logic [POS_W-1:0]       w_groups;
    logic [POS_W-1:0]       w_vlq_idx;
    logic [BYTE_W-1:0]      w_vlq_byte;
    logic [BYTE_W-1:0]      w_note_byte;
    logic                   w_event_end;
    logic                   w_back_on;
    logic                   w_back_off;

    mne_tick_unit u_tick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_tick_start),
        .i_diff  (w_tick_diff),
        .i_ratio (r_ratio),
        .o_rsp   (w_tick_rsp)
    );

    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_back_on  = i_start_stamp < r_prev;
    assign w_back_off = r_stop < r_prev;

    // vlq group count and the byte at the current position
    always_comb begin
        w_cur_ticks = r_evt ? r_ticks_off : r_ticks_on;
        w_groups    = POS_W'(1);
        for (int k = 1; k < VLQ_MAX_BYTES; k++) begin
            if ((w_cur_ticks >> (7 * k)) != '0) begin
                w_groups = w_groups + POS_W'(1);
            end
        end
        w_vlq_idx  = w_groups - POS_W'(1) - r_pos;
        w_vlq_byte = '0;
        for (int k = 0; k < VLQ_MAX_BYTES; k++) begin
            if (w_vlq_idx == POS_W'(k)) begin
                w_vlq_byte = {(k != 0) ? 1'b1 : 1'b0, 7'(w_cur_ticks >> (7 * k))};
            end
        end
        if (r_pos < w_groups) begin
            w_note_byte = w_vlq_byte;
        end else if (r_pos == w_groups) begin
            w_note_byte = r_evt ? NOTE_OFF_STATUS : NOTE_ON_STATUS;
        end else if (r_pos == w_groups + POS_W'(1)) begin
            w_note_byte = {1'b0, r_pitch};
        end else begin
            w_note_byte = {1'b0, r_vel};
        end
        w_event_end = (r_pos == w_groups + POS_W'(2));
    end

    // sequencer, config writes and output register
    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_ratio      = r_ratio;
        n_vel        = r_vel;
        n_func       = r_func;
        n_pitch      = r_pitch;
        n_stop       = r_stop;
        n_err        = r_err;
        n_ticks_on   = r_ticks_on;
        n_ticks_off  = r_ticks_off;
        n_evt        = r_evt;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_out_err    = r_out_err;
        w_tick_start = 1'b0;
        w_tick_diff  = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TICK_RATIO:    n_ratio = i_cfg_data;
                CFG_NOTE_VELOCITY: n_vel   = i_cfg_data[VEL_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func  = i_func;
                    n_pitch = i_pitch;
                    n_stop  = i_stop_stamp;
                    n_evt   = 1'b0;
                    n_pos   = '0;
                    if (i_func == FUNC_END) begin
                        n_prev  = '0;
                        n_err   = 1'b0;
                        n_state = S_EMIT;
                    end else begin
                        w_tick_start = 1'b1;
                        w_tick_diff  = w_back_on ? '0 : i_start_stamp - r_prev;
                        n_err        = w_back_on;
                        n_prev       = i_start_stamp;
                        n_state      = S_ON;
                    end
                end
            end
            S_ON: begin
                if (w_tick_rsp.done) begin
                    n_ticks_on   = w_tick_rsp.ticks;
                    w_tick_start = 1'b1;
                    w_tick_diff  = w_back_off ? '0 : r_stop - r_prev;
                    n_err        = r_err || w_back_off;
                    n_prev       = r_stop;
                    n_state      = S_OFF;
                end
            end
            S_OFF: begin
                if (w_tick_rsp.done) begin
                    n_ticks_off = w_tick_rsp.ticks;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_err;
                    if (r_func == FUNC_END) begin
                        n_out_byte = eot_byte(r_pos[1:0]);
                        n_out_last = (r_pos == POS_W'(EOT_LEN - 1));
                    end else begin
                        n_out_byte = w_note_byte;
                        n_out_last = r_evt && w_event_end;
                    end
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end else if (r_func == FUNC_NOTE && w_event_end) begin
                        n_evt = 1'b1;
                        n_pos = '0;
                    end else begin
                        n_pos = r_pos + POS_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_pitch     <= n_pitch;
        r_stop      <= n_stop;
        r_err       <= n_err;
        r_ticks_on  <= n_ticks_on;
        r_ticks_off <= n_ticks_off;
        r_evt       <= n_evt;
        r_pos       <= n_pos;
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_err   <= n_out_err;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_ratio     <= TICK_RATIO_RESET;
            r_vel       <= VELOCITY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_ratio     <= n_ratio;
            r_vel       <= n_vel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_byte   = r_out_last;
    assign o_order_error = r_out_err;

endmodule

@@ rtl/core/mne_checker.sv @@
// mne_checker: port-level assertions for the MIDI note event encoder, bound to the top
// depends on mne_pkg and midi_note_event_encoder_top
`timescale 1ns / 1ps

module mne_checker import mne_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [BYTE_W-1:0]      o_out_byte,
    input logic                   o_last_byte,
    input logic                   o_order_error
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_last_byte) && $stable(o_order_error))
        else $error("stalled output word changed");

    // an accepted request keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted but block not busy");

    // when idle, only the final byte of the previous request may still be pending
    a_idle_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && o_out_valid |-> o_last_byte)
        else $error("idle with a non-final byte pending");

    // bytes of one request follow back to back when the sink takes them
    a_next_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte |=> o_out_valid)
        else $error("gap inside a request's byte stream");

    // the error flag is the same on all bytes of one request
    a_err_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_byte
            |=> o_order_error == $past(o_order_error))
        else $error("order_error changed inside a request");

endmodule

bind midi_note_event_encoder_top mne_checker u_mne_checker (.*);

@@ dv/midi_note_event_encoder_top_test.sv @@
`timescale 1ns / 1ps
// midi_note_event_encoder_top_test: self-checking bench for the midi note event encoder
// predicts the track byte stream of every request word and compares it byte by byte
// depends on mne_pkg and midi_note_event_encoder_top

module midi_note_event_encoder_top_test;
    import mne_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 75;
    localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = '1;
    localparam logic [RATIO_W-1:0]     RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_W;

    // one expected byte word
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              err;
    } t_track_byte;

    // clock, reset and block ports
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_stall;
    logic                   i_func        = FUNC_NOTE;
    logic [PITCH_W-1:0]     i_pitch       = '0;
    logic [STAMP_WIDTH-1:0] i_start_stamp = '0;
    logic [STAMP_WIDTH-1:0] i_stop_stamp  = '0;
    logic                   o_out_valid;
    logic                   i_out_stall   = 1'b0;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_last_byte;
    logic                   o_order_error;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_TICK_RATIO;
    logic [RATIO_W-1:0]     i_cfg_data    = '0;

    // encoder state as the bench sees it
    logic [RATIO_W-1:0]     ratio_q    = TICK_RATIO_RESET;
    logic [VEL_W-1:0]       velocity_q = VELOCITY_RESET;
    logic [STAMP_WIDTH-1:0] last_stamp = '0;
    logic [BYTE_W-1:0]      event_bytes[$];
    t_track_byte            expected_track_bytes[$];
    t_track_byte            want_byte;

    // run control and statistics
    int   send_idle_pct     = 0;
    int   recv_stall_pct    = 0;
    logic long_hold_pending = 1'b0;
    int   hold_left         = 0;
    int   quiet_cycles      = 0;
    int   failures          = 0;
    int   requests_sent     = 0;
    int   bytes_checked     = 0;
    int   order_error_notes = 0;
    int   registers_written = 0;

    midi_note_event_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_pitch       (i_pitch),
        .i_start_stamp (i_start_stamp),
        .i_stop_stamp  (i_stop_stamp),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_order_error (o_order_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // delta ticks for one stamp, rounded half up and capped
    task automatic advance_stamp(input logic [STAMP_WIDTH-1:0] stamp,
                                 output logic [DELTA_W-1:0] ticks, inout logic backward);
        logic [79:0] diff;
        logic [79:0] scaled;
        if (stamp < last_stamp) begin
            backward = 1'b1;
            ticks    = '0;
        end else begin
            diff   = 80'(stamp - last_stamp);
            scaled = diff * 80'(ratio_q[RATIO_W-1:RATIO_FRAC_W])
                   + ((diff * 80'(ratio_q[RATIO_FRAC_W-1:0]) + 80'(ROUND_HALF))
                      >> RATIO_FRAC_W);
            ticks  = (scaled > 80'(DELTA_CAP)) ? DELTA_CAP : scaled[DELTA_W-1:0];
        end
        last_stamp = stamp;
    endtask

    // vlq delta, status, pitch, velocity
    task automatic append_event(input logic [DELTA_W-1:0] delta,
                                input logic [BYTE_W-1:0] status,
                                input logic [PITCH_W-1:0] pitch);
        int          groups;
        logic [63:0] wide;
        wide   = 64'(delta);
        groups = 1;
        while (groups < VLQ_MAX_BYTES && (wide >> (7 * groups)) != 0)
            groups++;
        for (int g = groups - 1; g >= 0; g--)
            event_bytes.push_back({g != 0, 7'(wide >> (7 * g))});
        event_bytes.push_back(status);
        event_bytes.push_back({1'b0, pitch});
        event_bytes.push_back({1'b0, velocity_q});
    endtask

    // expected byte words of one accepted request word
    task automatic encode_request(input logic func, input logic [PITCH_W-1:0] pitch,
                                  input logic [STAMP_WIDTH-1:0] start_stamp,
                                  input logic [STAMP_WIDTH-1:0] stop_stamp);
        logic [DELTA_W-1:0] on_ticks;
        logic [DELTA_W-1:0] off_ticks;
        logic               backward;
        backward = 1'b0;
        event_bytes.delete();
        if (func == FUNC_END) begin
            event_bytes.push_back(EOT_DELTA_BYTE);
            event_bytes.push_back(META_STATUS);
            event_bytes.push_back(META_END_TRACK);
            event_bytes.push_back(EOT_LEN_BYTE);
            last_stamp = '0;
        end else begin
            advance_stamp(start_stamp, on_ticks, backward);
            append_event(on_ticks, NOTE_ON_STATUS, pitch);
            advance_stamp(stop_stamp, off_ticks, backward);
            append_event(off_ticks, NOTE_OFF_STATUS, pitch);
        end
        if (backward)
            order_error_notes++;
        foreach (event_bytes[k])
            expected_track_bytes.push_back(
                t_track_byte'{event_bytes[k], k == event_bytes.size() - 1, backward});
    endtask

    // offer one request word, with random idle cycles ahead of it
    task automatic send_request(input logic func, input logic [PITCH_W-1:0] pitch,
                                input logic [STAMP_WIDTH-1:0] start_stamp,
                                input logic [STAMP_WIDTH-1:0] stop_stamp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_pitch       <= pitch;
        i_start_stamp <= start_stamp;
        i_stop_stamp  <= stop_stamp;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        encode_request(func, pitch, start_stamp, stop_stamp);
    endtask

    task automatic send_note(input logic [PITCH_W-1:0] pitch,
                             input logic [STAMP_WIDTH-1:0] start_stamp,
                             input logic [STAMP_WIDTH-1:0] stop_stamp);
        send_request(FUNC_NOTE, pitch, start_stamp, stop_stamp);
    endtask

    task automatic send_end();
        send_request(FUNC_END, PITCH_W'($urandom), STAMP_WIDTH'($urandom),
                     STAMP_WIDTH'($urandom));
    endtask

    // stop offering and let every expected byte word arrive
    task automatic wait_for_track_bytes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_track_bytes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one register write, only while the block is idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [RATIO_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        registers_written++;
        if (index == CFG_TICK_RATIO)
            ratio_q = data;
        else if (index == CFG_NOTE_VELOCITY)
            velocity_q = data[VEL_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic randomize_registers();
        logic [RATIO_W-1:0] ratio;
        case ($urandom_range(0, 3))
            0:       ratio = RATIO_W'($urandom);   // under one tick per sample
            1:       ratio = {8'd0, 8'($urandom), 32'($urandom)};
            2:       ratio = RATIO_W'({$urandom, $urandom});
            default: ratio = RATIO_W'($urandom_range(0, 2**24));
        endcase
        write_register(CFG_TICK_RATIO, ratio);
        // upper data bits are noise for the velocity register
        write_register(CFG_NOTE_VELOCITY, RATIO_W'({$urandom, $urandom}));
    endtask

    // mostly short gaps, now and then a huge one
    function automatic logic [31:0] random_gap();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2**26);
            1:       return 0;
            default: return $urandom_range(0, 4000);
        endcase
    endfunction

    // well-formed notes with some end of track, noise and backward stamps
    task automatic send_random_request();
        int                     kind;
        logic [PITCH_W-1:0]     pitch;
        logic [STAMP_WIDTH-1:0] start_stamp;
        logic [STAMP_WIDTH-1:0] stop_stamp;
        kind        = $urandom_range(0, 99);
        pitch       = PITCH_W'($urandom);
        start_stamp = last_stamp + STAMP_WIDTH'(random_gap());
        stop_stamp  = start_stamp + STAMP_WIDTH'(random_gap());
        if (kind < 6) begin
            send_end();
        end else begin
            if (kind < 14) begin
                start_stamp = STAMP_WIDTH'($urandom);
                stop_stamp  = STAMP_WIDTH'($urandom);
            end else if (kind < 20) begin
                if ($urandom_range(0, 1) == 0)
                    start_stamp = last_stamp - STAMP_WIDTH'($urandom_range(1, 3000));
                else
                    stop_stamp = start_stamp - STAMP_WIDTH'($urandom_range(1, 3000));
            end
            send_note(pitch, start_stamp, stop_stamp);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        randomize_registers();
        repeat (PHASE_ITEMS) send_random_request();
        wait_for_track_bytes();
    endtask

    // field extremes, stamp order errors, saturation, vlq lengths, rounding
    task automatic test_directed_extremes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_note(7'd0, '0, '0);
        send_note(7'd127, 31'd44100, 31'd88200);
        // start behind the last stamp, then stop behind start
        send_note(7'd60, 31'd1000, 31'd2000);
        send_note(7'd61, 31'd5000, 31'd4000);
        send_end();
        send_note(7'd64, STAMP_MAX, STAMP_MAX);
        send_end();
        wait_for_track_bytes();
        // largest ratio and velocity, delta saturates
        write_register(CFG_TICK_RATIO, '1);
        write_register(CFG_NOTE_VELOCITY, RATIO_W'(7'h7F));
        send_note(7'd1, 31'd1, STAMP_MAX);
        send_end();
        wait_for_track_bytes();
        // one tick per sample, vlq lengths one to five bytes
        write_register(CFG_TICK_RATIO, RATIO_ONE);
        write_register(CFG_NOTE_VELOCITY, '0);
        send_note(7'd2, 31'd127, 31'd255);
        send_note(7'd3, 31'd16639, 31'd2113791);
        send_note(7'd4, 31'd270549247, 31'd270549247);
        send_end();
        wait_for_track_bytes();
        // half a tick per sample, rounding half up
        write_register(CFG_TICK_RATIO, RATIO_ONE >> 1);
        send_note(7'd5, 31'd1, 31'd4);
        wait_for_track_bytes();
        // zero ratio
        write_register(CFG_TICK_RATIO, '0);
        send_note(7'd6, 31'd100, 31'd200);
        send_end();
        wait_for_track_bytes();
        write_register(CFG_TICK_RATIO, TICK_RATIO_RESET);
        write_register(CFG_NOTE_VELOCITY, RATIO_W'(VELOCITY_RESET));
    endtask

    task automatic test_no_idling();
        run_random_phase(0, 0);
    endtask

    task automatic test_sender_idle();
        run_random_phase(73, 0);
    endtask

    task automatic test_receiver_stall();
        run_random_phase(0, 73);
    endtask

    task automatic test_both_idle();
        run_random_phase(37, 37);
    endtask

    // long receiver hold while words keep coming, a full drain pause, then a batch with idling and stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        randomize_registers();
        long_hold_pending = 1'b1;
        repeat (30) send_random_request();
        wait_for_track_bytes();
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        repeat (10) send_random_request();
        wait_for_track_bytes();
    endtask

    // byte receiver: random stall or a long counted hold
    always @(negedge i_clk) begin
        if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // compare each byte word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            bytes_checked++;
            if (expected_track_bytes.size() == 0) begin
                $display("%0t: unexpected byte word: byte %02h last %0b err %0b",
                         $time, o_out_byte, o_last_byte, o_order_error);
                failures++;
            end else begin
                want_byte = expected_track_bytes.pop_front();
                if (o_out_byte !== want_byte.value || o_last_byte !== want_byte.last ||
                    o_order_error !== want_byte.err) begin
                    $display({"%0t: byte word mismatch: expected byte %02h last %0b ",
                              "err %0b, got byte %02h last %0b err %0b"},
                             $time, want_byte.value, want_byte.last, want_byte.err,
                             o_out_byte, o_last_byte, o_order_error);
                    failures++;
                end
            end
        end
    end

    // cycles in which no word moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles, %0d byte words outstanding",
                 $time, QUIET_LIMIT, expected_track_bytes.size());
        $display("midi_note_event_encoder_top_test failed");
        $finish;
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_no_idling();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d request words (%0d notes with stamp order errors), %0d byte words",
                 requests_sent, order_error_notes, bytes_checked);
        $display("%0d register writes across idle, stall and long hold phases",
                 registers_written);
        if (failures == 0) begin
            $display("midi_note_event_encoder_top_test passed");
        end else begin
            $display("midi_note_event_encoder_top_test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mne_pkg.sv
rtl/core/mne_tick_unit.sv
rtl/core/midi_note_event_encoder_top.sv
rtl/core/mne_checker.sv
dv/midi_note_event_encoder_top_test.sv
